/* rtl/lbmc_pkg.sv */
// Shared types and constants for the D3Q19 forced collision block.
// No dependencies.
package lbmc_pkg;

  // Configuration register index (byte address 4*index).
  localparam logic REG_RELAX_TIME = 1'b0;

  // Highest valid lattice direction.
  localparam logic [4:0] DIR_MAX = 5'd18;

  // Weight classes: rest, axis, diagonal.
  localparam logic [1:0] CLS_REST = 2'd0;
  localparam logic [1:0] CLS_AXIS = 2'd1;
  localparam logic [1:0] CLS_DIAG = 2'd2;

  // Lattice weights as unsigned Q0.31.
  localparam logic [31:0] W_REST = 32'd715827883;
  localparam logic [31:0] W_AXIS = 32'd119304647;
  localparam logic [31:0] W_DIAG = 32'd59652324;

  // D3Q19 velocity set.
  localparam logic signed [1:0] VEC_X [19] = '{
    2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd1,
    -2'sd1, 2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd0, 2'sd0};
  localparam logic signed [1:0] VEC_Y [19] = '{
    2'sd0, 2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd0,
    2'sd0, 2'sd1, -2'sd1, -2'sd1, 2'sd1, 2'sd0, 2'sd0, 2'sd1, -2'sd1};
  localparam logic signed [1:0] VEC_Z [19] = '{
    2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd1,
    -2'sd1, 2'sd1, -2'sd1, 2'sd0, 2'sd0, -2'sd1, 2'sd1, -2'sd1, 2'sd1};

  // Gravity: Fy = -floor((2 rho + G) / (2 G)), G = 2457600 = 2^15 * 75.
  localparam logic signed [33:0] GRAV_DIV    = 34'sd2457600;
  localparam int                  GRAV_SHIFT  = 16;       // 2G = 2^16 * 75
  localparam logic [17:0]         GRAV_OFFSET = 18'd76800; // 75 * 1024
  localparam logic [17:0]         GRAV_RECIP  = 18'd223696; // floor(2^24 / 75)
  localparam logic [11:0]         GRAV_BIAS   = 12'd1024;

  // Coefficients from tau, unsigned Q0.31 (value may reach 2^31).
  typedef struct packed {
    logic [31:0] ka;  // 0.5 / tau
    logic [31:0] kb;  // 1 / (tau + 0.5)
    logic [31:0] kc;  // tau / (tau + 0.5)
    logic [31:0] ks;  // 1 - 0.5 / tau
  } coef_t;

  typedef enum logic [1:0] {
    CO_LOAD,
    CO_RUN,
    CO_IDLE
  } co_state_t;

  // Fields that ride along the pipeline.
  typedef struct packed {
    logic signed [31:0] f;
    logic signed [31:0] r;
    logic signed [31:0] uy;
    logic signed [1:0]  cy;
    logic [1:0]         cls;
    logic               byp;
  } carry_t;

  function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
    logic signed [31:0] res;
    if (v > 80'sh7FFFFFFF) begin
      res = 32'sh7FFFFFFF;
    end else if (v < -80'sh80000000) begin
      res = -32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // Raw product of a Q0.31 coefficient and a data value.
  function automatic logic signed [64:0] mulc_raw(input logic [31:0] k,
                                                  input logic signed [31:0] x);
    return 65'($signed({1'b0, k})) * 65'(x);
  endfunction

  // Round a coefficient product to data scale.
  function automatic logic signed [33:0] rnd31(input logic signed [64:0] p);
    logic signed [64:0] t;
    t = (p + 65'sd1073741824) >>> 31;
    return t[33:0];
  endfunction

  // Multiply by a lattice component in {-1, 0, 1}.
  function automatic logic signed [33:0] cmul(input logic signed [1:0] c,
                                              input logic signed [32:0] x);
    logic signed [33:0] res;
    if (c == 2'sd1) begin
      res = 34'(x);
    end else if (c == -2'sd1) begin
      res = -34'(x);
    end else begin
      res = '0;
    end
    return res;
  endfunction

endpackage

/* rtl/lbmc_core.sv */
// Twelve-stage collision datapath: equilibrium, force, source, BGK update.
// Depends on lbmc_pkg; coefficients come from the top level.
module lbmc_core
  import lbmc_pkg::*;
#(
  parameter int FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  coef_t              coef,
  input  logic               coef_ok,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] dist_in,
  input  logic [4:0]         direction,
  input  logic signed [31:0] density,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] vel_z,
  input  logic signed [31:0] cur_x,
  input  logic signed [31:0] cur_y,
  input  logic signed [31:0] cur_z,
  input  logic signed [31:0] field_x,
  input  logic signed [31:0] field_y,
  input  logic signed [31:0] field_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] dist_out
);

  localparam int NS = 12;
  localparam logic signed [63:0] SEVEN_ONE = 64'sd7 <<< FRAC_BITS;
  localparam logic signed [63:0] RND_Q     = 64'sd1 <<< (FRAC_BITS - 1);

  // Data product rounded to FRAC_BITS and saturated.
  function automatic logic signed [31:0] mulq_fin(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + RND_Q) >>> FRAC_BITS;
    return sat32(80'(t));
  endfunction

  function automatic logic [31:0] wsel(input logic [1:0] cls);
    logic [31:0] w;
    unique case (cls)
      CLS_REST: w = W_REST;
      CLS_AXIS: w = W_AXIS;
      default:  w = W_DIAG;
    endcase
    return w;
  endfunction

  logic [NS:1] v, adv;
  carry_t      cr [1:NS-1];

  always_comb begin
    adv[NS] = !v[NS] || out_ready;
    for (int k = NS - 1; k >= 1; k--) begin
      adv[k] = !v[k] || adv[k + 1];
    end
  end

  assign in_ready  = adv[1] && coef_ok;
  assign out_valid = v[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[1]) v[1] <= in_valid && coef_ok;
      for (int k = 2; k <= NS; k++) begin
        if (adv[k]) v[k] <= v[k - 1];
      end
    end
  end

  // Stage 1 inputs
  logic               byp0;
  logic [4:0]         qi;
  logic signed [1:0]  cx0, cy0, cz0;
  logic signed [33:0] cus0;
  logic signed [33:0] nq0;
  logic signed [33:0] msh0;
  logic [17:0]        mp0;
  carry_t             c0;

  assign byp0 = direction > DIR_MAX;
  assign qi   = byp0 ? 5'd0 : direction;
  assign cx0  = VEC_X[qi];
  assign cy0  = VEC_Y[qi];
  assign cz0  = VEC_Z[qi];
  assign cus0 = cmul(cx0, 33'(vel_x)) + cmul(cy0, 33'(vel_y)) + cmul(cz0, 33'(vel_z));
  assign nq0  = {density[31], density, 1'b0} + GRAV_DIV;
  assign msh0 = nq0 >>> GRAV_SHIFT;
  assign mp0  = msh0[17:0] + GRAV_OFFSET;

  always_comb begin
    c0.f   = dist_in;
    c0.r   = density;
    c0.uy  = vel_y;
    c0.cy  = cy0;
    c0.byp = byp0;
    if (qi == 5'd0) begin
      c0.cls = CLS_REST;
    end else if (qi <= 5'd6) begin
      c0.cls = CLS_AXIS;
    end else begin
      c0.cls = CLS_DIAG;
    end
  end

  // side fields move with their stage
  always_ff @(posedge clk) begin
    if (adv[1]) cr[1] <= c0;
    for (int k = 2; k <= NS - 1; k++) begin
      if (adv[k]) cr[k] <= cr[k - 1];
    end
  end

  function automatic logic signed [31:0] lever(input logic signed [1:0] c,
                                               input logic signed [31:0] u);
    logic signed [63:0] b;
    if (c == 2'sd1) begin
      b = SEVEN_ONE;
    end else if (c == -2'sd1) begin
      b = -SEVEN_ONE;
    end else begin
      b = '0;
    end
    return sat32(80'(b - 64'(u)));
  endfunction

  // R1
  logic signed [31:0] cu_s1, l1_s1, l2_s1, l3_s1;
  logic signed [63:0] pxx_s1, pyy_s1, pzz_s1;
  logic signed [63:0] jxbz_s1, jzby_s1, jzbx_s1, jybx_s1, jxby_s1;
  logic [35:0]        gm_s1;
  logic [17:0]        mp_s1;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      cu_s1   <= sat32(80'(cus0));
      l1_s1   <= lever(cx0, vel_x);
      l2_s1   <= lever(cy0, vel_y);
      l3_s1   <= lever(cz0, vel_z);
      pxx_s1  <= 64'(vel_x) * 64'(vel_x);
      pyy_s1  <= 64'(vel_y) * 64'(vel_y);
      pzz_s1  <= 64'(vel_z) * 64'(vel_z);
      jxbz_s1 <= 64'(cur_x) * 64'(field_z);
      jzby_s1 <= 64'(cur_z) * 64'(field_y);
      jzbx_s1 <= 64'(cur_z) * 64'(field_x);
      jybx_s1 <= 64'(cur_y) * 64'(field_x);
      jxby_s1 <= 64'(cur_x) * 64'(field_y);
      gm_s1   <= 36'(mp0) * 36'(GRAV_RECIP);
      mp_s1   <= mp0;
    end
  end

  // Stage 2: u^2, cross terms, gravity quotient correction
  logic [11:0]        gq0;
  logic signed [19:0] grem;
  logic [11:0]        gq;
  logic signed [12:0] gfl;

  assign gq0  = gm_s1[35:24];
  assign grem = $signed({2'b00, mp_s1}) - $signed(20'(gq0) * 20'd75);
  assign gq   = (grem >= 20'sd75) ? gq0 + 12'd1 : gq0;
  assign gfl  = $signed({1'b0, gq}) - $signed({1'b0, GRAV_BIAS});

  logic signed [31:0] cu_s2, u2_s2, m1_s2, m2_s2, m3_s2, l1_s2, l2_s2, l3_s2, fy_s2;
  logic signed [63:0] cc_s2;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      cu_s2 <= cu_s1;
      cc_s2 <= 64'(cu_s1) * 64'(cu_s1);
      u2_s2 <= sat32(80'(mulq_fin(pxx_s1)) + 80'(mulq_fin(pyy_s1)) + 80'(mulq_fin(pzz_s1)));
      m1_s2 <= sat32(80'(mulq_fin(jxbz_s1)) - 80'(mulq_fin(jzby_s1)));
      m2_s2 <= sat32(80'(mulq_fin(jzbx_s1)) - 80'(mulq_fin(jxbz_s1)));
      m3_s2 <= sat32(80'(mulq_fin(jybx_s1)) - 80'(mulq_fin(jxby_s1)));
      l1_s2 <= l1_s1;
      l2_s2 <= l2_s1;
      l3_s2 <= l3_s1;
      fy_s2 <= -32'(gfl);
    end
  end

  // Stage 3: polynomial, lever products, gravity products
  logic signed [39:0] pacc;
  assign pacc = 40'sd6 * 40'(cu_s2) + 40'sd9 * 40'(mulq_fin(cc_s2)) - 40'sd3 * 40'(u2_s2)
              + 40'sd1;

  logic signed [31:0] poly_s3, fy_s3;
  logic signed [63:0] lm1_s3, lm2_s3, lm3_s3, fcu_s3, ufy_s3;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      poly_s3 <= sat32(80'(pacc >>> 1));
      lm1_s3  <= 64'(l1_s2) * 64'(m1_s2);
      lm2_s3  <= 64'(l2_s2) * 64'(m2_s2);
      lm3_s3  <= 64'(l3_s2) * 64'(m3_s2);
      fcu_s3  <= 64'(fy_s2) * 64'(cu_s2);
      ufy_s3  <= 64'(cr[2].uy) * 64'(fy_s2);
      fy_s3   <= fy_s2;
    end
  end

  // Stage 4: r*poly product, force sum, source sum
  logic signed [33:0] t1_4, t2_4;
  logic signed [39:0] src_acc;
  assign t1_4    = cmul($signed(cr[3].cy), 33'(fy_s3));
  assign t2_4    = cmul($signed(cr[3].cy), 33'(mulq_fin(fcu_s3)));
  assign src_acc = 40'sd3 * 40'(t1_4) + 40'sd9 * 40'(t2_4) - 40'sd3 * 40'(mulq_fin(ufy_s3));

  logic signed [63:0] rp_s4;
  logic signed [31:0] sum_s4, src_s4;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      rp_s4  <= 64'(cr[3].r) * 64'(poly_s3);
      sum_s4 <= sat32(80'(mulq_fin(lm1_s3)) + 80'(mulq_fin(lm2_s3)) + 80'(mulq_fin(lm3_s3)));
      src_s4 <= sat32(80'(src_acc));
    end
  end

  // Stage 5
  logic signed [31:0] feqp_s5;
  logic signed [63:0] rs_s5;
  logic signed [64:0] ws_s5;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      feqp_s5 <= sat32(80'(cr[4].r) + 80'(mulq_fin(rp_s4)));
      rs_s5   <= 64'(cr[4].r) * 64'(sum_s4);
      ws_s5   <= mulc_raw(wsel(cr[4].cls), src_s4);
    end
  end

  // Stage 6: acel from rho*sum with the weight scaling
  logic signed [35:0] mm6, acc6;
  assign mm6 = 36'(mulq_fin(rs_s5));
  always_comb begin
    unique case (cr[5].cls)
      CLS_REST: acc6 = -(36'sd3 * mm6);
      CLS_AXIS: acc6 = (36'sd1 - mm6) >>> 1;
      default:  acc6 = (36'sd2 - mm6) >>> 2;
    endcase
  end

  logic signed [64:0] wf_s6;
  logic signed [31:0] acel_s6, wsrc_s6;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      wf_s6   <= mulc_raw(wsel(cr[5].cls), feqp_s5);
      acel_s6 <= sat32(80'(acc6));
      wsrc_s6 <= sat32(80'(rnd31(ws_s5)));
    end
  end

  // Stage 7
  logic signed [31:0] feq_s7;
  logic signed [64:0] kaa_s7, kca_s7, ksw_s7;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      feq_s7 <= sat32(80'(rnd31(wf_s6)));
      kaa_s7 <= mulc_raw(coef.ka, acel_s6);
      kca_s7 <= mulc_raw(coef.kc, acel_s6);
      ksw_s7 <= mulc_raw(coef.ks, wsrc_s6);
    end
  end

  // Stage 8
  logic signed [31:0] feq_s8, d1_s8, p_s8;
  logic signed [33:0] kaa_s8, kca_s8;

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      feq_s8 <= feq_s7;
      d1_s8  <= sat32(80'(cr[7].f) - 80'(feq_s7));
      kaa_s8 <= rnd31(kaa_s7);
      kca_s8 <= rnd31(kca_s7);
      p_s8   <= sat32(80'(rnd31(ksw_s7)));
    end
  end

  // Stage 9
  logic signed [31:0] feq_s9, p_s9;
  logic signed [33:0] kaa_s9, kca_s9;
  logic signed [64:0] kd1_s9;

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      feq_s9 <= feq_s8;
      kaa_s9 <= kaa_s8;
      kca_s9 <= kca_s8;
      p_s9   <= p_s8;
      kd1_s9 <= mulc_raw(coef.ka, d1_s8);
    end
  end

  // Stage 10: fbar and fbar - feq
  logic signed [31:0] fbar10;
  assign fbar10 = sat32(80'(cr[9].f) + 80'(rnd31(kd1_s9)) - 80'(kaa_s9));

  logic signed [31:0] fbar_s10, d2_s10, p_s10;
  logic signed [33:0] kca_s10;

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      fbar_s10 <= fbar10;
      d2_s10   <= sat32(80'(fbar10) - 80'(feq_s9));
      kca_s10  <= kca_s9;
      p_s10    <= p_s9;
    end
  end

  // Stage 11
  logic signed [31:0] fbar_s11, p_s11;
  logic signed [33:0] kca_s11;
  logic signed [64:0] kd2_s11;

  always_ff @(posedge clk) begin
    if (adv[11]) begin
      fbar_s11 <= fbar_s10;
      kca_s11  <= kca_s10;
      p_s11    <= p_s10;
      kd2_s11  <= mulc_raw(coef.kb, d2_s10);
    end
  end

  // Stage 12: output register
  logic signed [31:0] res12;
  assign res12 = sat32(80'(fbar_s11) - 80'(rnd31(kd2_s11)) + 80'(kca_s11) + 80'(p_s11));

  always_ff @(posedge clk) begin
    if (adv[12]) begin
      dist_out <= cr[11].byp ? cr[11].f : res12;
    end
  end

endmodule

/* rtl/lbm_d3q19_forced_collision.sv */
// D3Q19 lattice Boltzmann collision with electromagnetic and gravity forcing.
// Top level: APB register, tau coefficient divider, datapath lbmc_core.
// Depends on lbmc_pkg and lbmc_core.
//
// Usage
//   Input channel (in_valid/in_ready): one transaction per lattice element
//   carries the pre-collision value, its direction and the cell moments.
//   Output channel (out_valid/out_ready): one post-collision value per input
//   transaction, in order. Values are signed fixed point, FRAC_BITS fraction
//   bits, saturated on overflow. A direction above 18 passes dist_in through.
//   APB port: register 0 at address 0 holds tau (relax_time), unsigned.
// Throughput
//   One transaction per cycle sustained while out_ready stays high and no
//   coefficient computation holds in_ready low. The datapath is a 12-stage
//   pipeline, at most one multiplier level per stage.
// Reset and configuration
//   After rst, and after each write of relax_time, a shared restoring divider
//   forms the four tau coefficients, one quotient bit per cycle, each job
//   after a load state; in_ready stays low meanwhile. Reset loads tau = 0.6.
// Stall behavior
//   Each stage holds while the one after it is full and blocked, so empty
//   stages keep filling while a finished result waits in the output register.
module lbm_d3q19_forced_collision
  import lbmc_pkg::*;
#(
  parameter int FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  // APB
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] dist_in,
  input  logic [4:0]         direction,
  input  logic signed [31:0] density,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] vel_z,
  input  logic signed [31:0] cur_x,
  input  logic signed [31:0] cur_y,
  input  logic signed [31:0] cur_z,
  input  logic signed [31:0] field_x,
  input  logic signed [31:0] field_y,
  input  logic signed [31:0] field_z,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] dist_out
);

  // tau and half need the wider of 31 bits and FRAC_BITS, plus one
  localparam int TW = ((FRAC_BITS > 31) ? FRAC_BITS : 31) + 1;
  localparam int DW = TW + 2;
  localparam logic [DW-1:0] HALF = DW'(1) << (FRAC_BITS - 1);

  logic [30:0] relax_time;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && (paddr[2] == REG_RELAX_TIME);
  assign prdata = (paddr[2] == REG_RELAX_TIME) ? {1'b0, relax_time} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      relax_time <= 31'd10066330;  // 0.6 at Q7.24
    end else if (wr) begin
      relax_time <= pwdata[30:0];
    end
  end

  // tau clamped above one half
  logic [DW-1:0] tau_x, tau_e, num, den;
  assign tau_x = DW'(relax_time);
  assign tau_e = (tau_x <= HALF) ? HALF + DW'(1) : tau_x;

  co_state_t     state, state_next;
  logic [1:0]    idx;
  logic [4:0]    step;
  logic [DW-1:0] rem, rem_sh;
  logic [31:0]   quo, quo_fin;
  logic          ge, last;
  logic          coef_ok;
  coef_t         coef;

  // divider jobs: ka, kb, kc, ks
  always_comb begin
    unique case (idx)
      2'd0: begin
        num = HALF;
        den = tau_e;
      end
      2'd1: begin
        num = HALF << 1;
        den = tau_e + HALF;
      end
      2'd2: begin
        num = tau_e;
        den = tau_e + HALF;
      end
      default: begin
        num = tau_e - HALF;
        den = tau_e;
      end
    endcase
  end

  assign rem_sh  = rem << 1;
  assign ge      = rem_sh >= den;
  assign quo_fin = {quo[30:0], ge};
  assign last    = (step == 5'd31);

  // next state
  always_comb begin
    state_next = state;
    priority if (wr) begin
      state_next = CO_LOAD;
    end else begin
      unique case (state)
        CO_LOAD: state_next = CO_RUN;
        CO_RUN:  if (last) state_next = (idx == 2'd3) ? CO_IDLE : CO_LOAD;
        default: state_next = CO_IDLE;
      endcase
    end
  end

  // outputs
  always_comb begin
    unique case (state)
      CO_IDLE: coef_ok = 1'b1;
      default: coef_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CO_LOAD;
      idx   <= 2'd0;
    end else begin
      state <= state_next;
      if (wr) begin
        idx <= 2'd0;
      end else if (state == CO_RUN && last) begin
        idx <= idx + 2'd1;
      end
    end
  end

  // divider datapath
  logic [32:0] kval;
  assign kval = (33'(quo_fin) + 33'd1) >> 1;

  always_ff @(posedge clk) begin
    if (state == CO_LOAD) begin
      rem  <= num;
      quo  <= '0;
      step <= '0;
    end else if (state == CO_RUN) begin
      rem  <= ge ? rem_sh - den : rem_sh;
      quo  <= quo_fin;
      step <= step + 5'd1;
      if (last) begin
        unique case (idx)
          2'd0:    coef.ka <= kval[31:0];
          2'd1:    coef.kb <= kval[31:0];
          2'd2:    coef.kc <= kval[31:0];
          default: coef.ks <= kval[31:0];
        endcase
      end
    end
  end

  lbmc_core #(
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef),
    .coef_ok   (coef_ok),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .dist_in   (dist_in),
    .direction (direction),
    .density   (density),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .vel_z     (vel_z),
    .cur_x     (cur_x),
    .cur_y     (cur_y),
    .cur_z     (cur_z),
    .field_x   (field_x),
    .field_y   (field_y),
    .field_z   (field_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dist_out  (dist_out)
  );

endmodule
